>>> hdl/barometric_pressure_compensation_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the barometric pressure compensation core
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_CORE_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_CORE_ASSERT_SVH

// same-cycle implication
`define BPC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("bpc assertion failed");

// implication after a fixed number of cycles
`define BPC_ASSERT_DLY(lbl, clk, rstn, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##(dly) (cons)) \
    else $error("bpc assertion failed");

`endif

>>> hdl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants shared by the barometric compensation core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_FIRST_THREE = 3'd0,
    CFG_A_FOUR        = 3'd1,
    CFG_A_FIVE        = 3'd2,
    CFG_A_SIX         = 3'd3,
    CFG_B_PAIR        = 3'd4,
    CFG_M_PAIR        = 3'd5,
    CFG_OVERSAMPLING  = 3'd6
  } cfg_idx_e;

  // long divider widths
  localparam int DIV_NUM_W = 33;
  localparam int DIV_DEN_W = 19;

  // accept to result strobe
  localparam int PIPE_LAT = 2 * DIV_NUM_W + 14;

  localparam int B6_OFFSET = 4000;
  localparam int B7_SCALE = 50000;
  localparam int B4_OFFSET = 32768;
  localparam int P_C1 = 3038;
  localparam int P_C2 = -7357;
  localparam int P_C3 = 3791;
  localparam int TEMP_MAX = 32767;
  localparam int TEMP_MIN = -32768;
  localparam int PRESS_MAX = 1048575;

endpackage

>>> hdl/barometric_pressure_compensation_core.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_core
// Integer temperature and pressure compensation of a barometer sample.
// ----------------------------------------------------------------------------
// channel  | direction | handshake                  | word
// sample   | in        | start_i high, busy_o low   | raw temperature, pressure bytes
// config   | in        | cfg_valid_i & cfg_ready_o  | cfg_index_i, cfg_data_i
// result   | out       | result_valid_o, one cycle  | temperature_tenths_o, pressure_pa_o
//
// One sample per cycle. The pipeline is built from two 33-stage pipelined
// dividers plus fourteen arithmetic stages. Reset clears the valid chain
// and the calibration registers.
// busy_o stays low and cfg_ready_o stays high; the receiver cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module barometric_pressure_compensation_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [15:0]                    raw_temperature_i,
  input  logic [7:0]                     press_msb_i,
  input  logic [7:0]                     press_lsb_i,
  input  logic [7:0]                     press_xlsb_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           result_valid_o,
  output logic signed [15:0]             temperature_tenths_o,
  output logic [19:0]                    pressure_pa_o
);
  import bpc_pkg::*;

  localparam int DL = DIV_NUM_W;

  // calibration
  logic [47:0] cal_a123_q;
  logic [15:0] cal_a4_q, cal_a5_q, cal_a6_q;
  logic [31:0] cal_b_q, cal_m_q;
  logic [1:0]  oss_q;

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;

  assign ac1 = $signed(cal_a123_q[47:32]);
  assign ac2 = $signed(cal_a123_q[31:16]);
  assign ac3 = $signed(cal_a123_q[15:0]);
  assign b1  = $signed(cal_b_q[31:16]);
  assign b2  = $signed(cal_b_q[15:0]);
  assign mc  = $signed(cal_m_q[31:16]);
  assign md  = $signed(cal_m_q[15:0]);

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_a123_q <= '0;
      cal_a4_q   <= '0;
      cal_a5_q   <= '0;
      cal_a6_q   <= '0;
      cal_b_q    <= '0;
      cal_m_q    <= '0;
      oss_q      <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_A_FIRST_THREE: cal_a123_q <= cfg_data_i[47:0];
        CFG_A_FOUR:        cal_a4_q   <= cfg_data_i[15:0];
        CFG_A_FIVE:        cal_a5_q   <= cfg_data_i[15:0];
        CFG_A_SIX:         cal_a6_q   <= cfg_data_i[15:0];
        CFG_B_PAIR:        cal_b_q    <= cfg_data_i[31:0];
        CFG_M_PAIR:        cal_m_q    <= cfg_data_i[31:0];
        CFG_OVERSAMPLING:  oss_q      <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // valid chain
  logic          v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;
  logic          v12_q, v13_q, v14_q, v15_q;
  logic [DL-1:0] d1_v_q, d2_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      d1_v_q <= '0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      v8_q   <= 1'b0;
      v9_q   <= 1'b0;
      v10_q  <= 1'b0;
      d2_v_q <= '0;
      v12_q  <= 1'b0;
      v13_q  <= 1'b0;
      v14_q  <= 1'b0;
      v15_q  <= 1'b0;
    end else begin
      v1_q   <= start_i && !busy_o;
      v2_q   <= v1_q;
      d1_v_q <= {d1_v_q[DL-2:0], v2_q};
      v3_q   <= d1_v_q[DL-1];
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      v7_q   <= v6_q;
      v8_q   <= v7_q;
      v9_q   <= v8_q;
      v10_q  <= v9_q;
      d2_v_q <= {d2_v_q[DL-2:0], v10_q};
      v12_q  <= d2_v_q[DL-1];
      v13_q  <= v12_q;
      v14_q  <= v13_q;
      v15_q  <= v14_q;
    end
  end

  // stage 1: raw pressure, (ut - ac6) * ac5
  logic [23:0]        raw_pr;
  logic [18:0]        up_d;
  logic signed [16:0] ut_diff;
  logic signed [33:0] prod1_d;

  assign raw_pr  = {press_msb_i, press_lsb_i, press_xlsb_i};
  assign up_d    = 19'(raw_pr >> (4'd8 - {2'b00, oss_q}));
  assign ut_diff = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, cal_a6_q});
  assign prod1_d = ut_diff * $signed({1'b0, cal_a5_q});

  logic [18:0]        up_q1;
  logic signed [33:0] prod1_q1;

  // stage 2: divisor and numerator magnitudes
  logic signed [18:0] x1t_d;
  logic signed [19:0] tdiv;
  logic [15:0]        mc_mag;

  assign x1t_d  = 19'(prod1_q1 >>> 15);
  assign tdiv   = 20'(x1t_d) + 20'(md);
  assign mc_mag = mc[15] ? 16'(-mc) : 16'(mc);

  logic signed [18:0]    x1t_q2;
  logic                  tneg_q2, tdz_q2;
  logic [26:0]           tnum_q2;
  logic [DIV_DEN_W-1:0]  tden_q2;
  logic [18:0]           up_q2;

  logic [DIV_NUM_W-1:0] tquo;

  bpc_udiv u_tdiv (
    .clk_i (clk_i),
    .num_i ({{(DIV_NUM_W-27){1'b0}}, tnum_q2}),
    .den_i (tden_q2),
    .quo_o (tquo)
  );

  logic signed [18:0] d1_x1t_q [DL];
  logic               d1_neg_q [DL];
  logic               d1_dz_q  [DL];
  logic [18:0]        d1_up_q  [DL];

  // stage 3: b5
  logic signed [27:0] tq_s, x2t_d;
  logic signed [28:0] b5_d;

  assign tq_s  = $signed({1'b0, tquo[26:0]});
  assign x2t_d = d1_dz_q[DL-1] ? 28'sd0 : (d1_neg_q[DL-1] ? -tq_s : tq_s);
  assign b5_d  = 29'(d1_x1t_q[DL-1]) + 29'(x2t_d);

  logic signed [28:0] b5_q3;
  logic [18:0]        up_q3;

  // stage 4: b6 and temperature
  logic signed [29:0] b6_d;
  logic signed [29:0] tsum;
  logic signed [25:0] tt;
  logic signed [15:0] t_d;

  assign b6_d = 30'(b5_q3) - 30'(B6_OFFSET);
  assign tsum = 30'(b5_q3) + 30'sd8;
  assign tt   = 26'(tsum >>> 4);

  always_comb begin
    if (tt > 26'(TEMP_MAX)) begin
      t_d = 16'(TEMP_MAX);
    end else if (tt < 26'(TEMP_MIN)) begin
      t_d = 16'(TEMP_MIN);
    end else begin
      t_d = tt[15:0];
    end
  end

  logic signed [29:0] b6_q4;
  logic signed [15:0] t_q4, t_q5, t_q6, t_q7, t_q8, t_q9, t_q10;
  logic [18:0]        up_q4, up_q5, up_q6, up_q7, up_q8, up_q9;

  // stage 5: products of b6
  logic signed [59:0] sqf_d;
  logic signed [45:0] ac2b6_d, ac3b6_d;

  assign sqf_d   = b6_q4 * b6_q4;
  assign ac2b6_d = ac2 * b6_q4;
  assign ac3b6_d = ac3 * b6_q4;

  logic signed [59:0] sqf_q5;
  logic signed [45:0] ac2b6_q5, ac3b6_q5, ac2b6_q6, ac3b6_q6, ac2b6_q7, ac3b6_q7;

  // stage 6: partial products of sq
  logic [23:0]        sq_lo, sq_hi;
  logic signed [40:0] pp_b2l_d, pp_b2h_d, pp_b1l_d, pp_b1h_d;

  assign sq_lo    = sqf_q5[35:12];
  assign sq_hi    = sqf_q5[59:36];
  assign pp_b2l_d = b2 * $signed({1'b0, sq_lo});
  assign pp_b2h_d = b2 * $signed({1'b0, sq_hi});
  assign pp_b1l_d = b1 * $signed({1'b0, sq_lo});
  assign pp_b1h_d = b1 * $signed({1'b0, sq_hi});

  logic signed [40:0] pp_b2l_q6, pp_b2h_q6, pp_b1l_q6, pp_b1h_q6;

  // stage 7: b2 * sq and b1 * sq
  logic signed [63:0] b2sq_d, b1sq_d;

  assign b2sq_d = (64'(pp_b2h_q6) <<< 24) + 64'(pp_b2l_q6);
  assign b1sq_d = (64'(pp_b1h_q6) <<< 24) + 64'(pp_b1l_q6);

  logic signed [63:0] b2sq_q7, b1sq_q7;

  // stage 8: x3 sums
  logic signed [63:0] x3a_d, xsb_d;

  assign x3a_d = (b2sq_q7 >>> 11) + 64'(ac2b6_q7 >>> 11);
  assign xsb_d = 64'(ac3b6_q7 >>> 13) + (b1sq_q7 >>> 16);

  logic signed [63:0] x3a_q8, xsb_q8;

  // stage 9: b3 and x3
  logic signed [63:0] b3_sum, b3_sh, b3_full, x3c_full;

  assign b3_sum   = (64'(ac1) <<< 2) + x3a_q8;
  assign b3_sh    = b3_sum <<< oss_q;
  assign b3_full  = (b3_sh + 64'sd2) >>> 2;
  assign x3c_full = (xsb_q8 + 64'sd2) >>> 2;

  logic [31:0] b3_q9, x3c_q9;

  // stage 10: b4 and b7
  logic [31:0] b4_sum, b7_diff;
  logic [15:0] b7_scale;
  logic [47:0] b4_prod, b7_prod;

  assign b4_sum   = x3c_q9 + 32'(B4_OFFSET);
  assign b4_prod  = cal_a4_q * b4_sum;
  assign b7_diff  = {13'b0, up_q9} - b3_q9;
  assign b7_scale = 16'(B7_SCALE >> oss_q);
  assign b7_prod  = b7_diff * b7_scale;

  logic [16:0] b4_q10;
  logic [31:0] b7_q10;

  logic big;
  assign big = b7_q10[31];

  logic [DIV_NUM_W-1:0] pquo;

  bpc_udiv u_pdiv (
    .clk_i (clk_i),
    .num_i (big ? {1'b0, b7_q10} : {b7_q10, 1'b0}),
    .den_i ({{(DIV_DEN_W-17){1'b0}}, b4_q10}),
    .quo_o (pquo)
  );

  logic               d2_big_q [DL];
  logic               d2_b4z_q [DL];
  logic signed [15:0] d2_t_q   [DL];

  // stage 12: p
  logic [33:0] p_d;
  assign p_d = d2_big_q[DL-1] ? {pquo, 1'b0} : {1'b0, pquo};

  logic [33:0]        p_q12, p_q13, p_q14;
  logic               b4z_q12, b4z_q13, b4z_q14;
  logic signed [15:0] t_q12, t_q13, t_q14;

  // stage 13: (p >> 8)^2 and -7357 * p
  logic [25:0]        ps;
  logic [51:0]        sqp_d;
  logic signed [48:0] m2_d;

  assign ps    = p_q12[33:8];
  assign sqp_d = ps * ps;
  assign m2_d  = 14'(P_C2) * $signed({1'b0, p_q12});

  logic [51:0]        sqp_q13;
  logic signed [48:0] m2_q13;

  // stage 14: scaled terms
  logic [63:0]        x1p_full;
  logic [47:0]        x1p_d;
  logic signed [32:0] x2p_d;

  assign x1p_full = sqp_q13 * 12'(P_C1);
  assign x1p_d    = x1p_full[63:16];
  assign x2p_d    = 33'(m2_q13 >>> 16);

  logic [47:0]        x1p_q14;
  logic signed [32:0] x2p_q14;

  // stage 15: final pressure
  logic signed [49:0] padj_sum, padj;
  logic signed [50:0] pf;
  logic [19:0]        pa_d;

  assign padj_sum = $signed({2'b00, x1p_q14}) + 50'(x2p_q14) + 50'(P_C3);
  assign padj     = padj_sum >>> 4;
  assign pf       = $signed({17'b0, p_q14}) + 51'(padj);

  always_comb begin
    if (b4z_q14) begin
      pa_d = 20'(PRESS_MAX);
    end else if (pf < 51'sd0) begin
      pa_d = '0;
    end else if (pf > 51'(PRESS_MAX)) begin
      pa_d = 20'(PRESS_MAX);
    end else begin
      pa_d = pf[19:0];
    end
  end

  logic signed [15:0] t_q15;
  logic [19:0]        pa_q15;

  // datapath registers
  always_ff @(posedge clk_i) begin
    up_q1    <= up_d;
    prod1_q1 <= prod1_d;

    x1t_q2  <= x1t_d;
    tneg_q2 <= mc[15] ^ tdiv[19];
    tdz_q2  <= (tdiv == 20'sd0);
    tnum_q2 <= {mc_mag, 11'b0};
    tden_q2 <= tdiv[19] ? 19'(-tdiv) : 19'(tdiv);
    up_q2   <= up_q1;

    d1_x1t_q[0] <= x1t_q2;
    d1_neg_q[0] <= tneg_q2;
    d1_dz_q[0]  <= tdz_q2;
    d1_up_q[0]  <= up_q2;
    for (int i = 1; i < DL; i++) begin
      d1_x1t_q[i] <= d1_x1t_q[i-1];
      d1_neg_q[i] <= d1_neg_q[i-1];
      d1_dz_q[i]  <= d1_dz_q[i-1];
      d1_up_q[i]  <= d1_up_q[i-1];
    end

    b5_q3 <= b5_d;
    up_q3 <= d1_up_q[DL-1];

    b6_q4 <= b6_d;
    t_q4  <= t_d;
    up_q4 <= up_q3;

    sqf_q5   <= sqf_d;
    ac2b6_q5 <= ac2b6_d;
    ac3b6_q5 <= ac3b6_d;
    t_q5     <= t_q4;
    up_q5    <= up_q4;

    pp_b2l_q6 <= pp_b2l_d;
    pp_b2h_q6 <= pp_b2h_d;
    pp_b1l_q6 <= pp_b1l_d;
    pp_b1h_q6 <= pp_b1h_d;
    ac2b6_q6  <= ac2b6_q5;
    ac3b6_q6  <= ac3b6_q5;
    t_q6      <= t_q5;
    up_q6     <= up_q5;

    b2sq_q7  <= b2sq_d;
    b1sq_q7  <= b1sq_d;
    ac2b6_q7 <= ac2b6_q6;
    ac3b6_q7 <= ac3b6_q6;
    t_q7     <= t_q6;
    up_q7    <= up_q6;

    x3a_q8 <= x3a_d;
    xsb_q8 <= xsb_d;
    t_q8   <= t_q7;
    up_q8  <= up_q7;

    b3_q9  <= b3_full[31:0];
    x3c_q9 <= x3c_full[31:0];
    t_q9   <= t_q8;
    up_q9  <= up_q8;

    b4_q10 <= b4_prod[31:15];
    b7_q10 <= b7_prod[31:0];
    t_q10  <= t_q9;

    d2_big_q[0] <= big;
    d2_b4z_q[0] <= (b4_q10 == 17'd0);
    d2_t_q[0]   <= t_q10;
    for (int i = 1; i < DL; i++) begin
      d2_big_q[i] <= d2_big_q[i-1];
      d2_b4z_q[i] <= d2_b4z_q[i-1];
      d2_t_q[i]   <= d2_t_q[i-1];
    end

    p_q12   <= p_d;
    b4z_q12 <= d2_b4z_q[DL-1];
    t_q12   <= d2_t_q[DL-1];

    sqp_q13 <= sqp_d;
    m2_q13  <= m2_d;
    p_q13   <= p_q12;
    b4z_q13 <= b4z_q12;
    t_q13   <= t_q12;

    x1p_q14 <= x1p_d;
    x2p_q14 <= x2p_d;
    p_q14   <= p_q13;
    b4z_q14 <= b4z_q13;
    t_q14   <= t_q13;

    pa_q15 <= pa_d;
    t_q15  <= t_q14;
  end

  assign result_valid_o       = v15_q;
  assign temperature_tenths_o = t_q15;
  assign pressure_pa_o        = pa_q15;

endmodule

>>> hdl/bpc_udiv.sv
// ----------------------------------------------------------------------------
// bpc_udiv
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_udiv (
  input  logic                          clk_i,
  input  logic [bpc_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [bpc_pkg::DIV_DEN_W-1:0] den_i,
  output logic [bpc_pkg::DIV_NUM_W-1:0] quo_o
);
  import bpc_pkg::*;

  logic [DIV_NUM_W-1:0] num_q [DIV_NUM_W];
  logic [DIV_DEN_W-1:0] rem_q [DIV_NUM_W-1];
  logic [DIV_DEN_W-1:0] den_q [DIV_NUM_W-1];

  for (genvar k = 0; k < DIV_NUM_W; k++) begin : g_stage
    logic [DIV_NUM_W-1:0] num_in;
    logic [DIV_DEN_W-1:0] rem_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    if (k == 0) begin : g_first
      assign num_in = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign num_in = num_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, num_in[DIV_NUM_W-1]};
    assign ge    = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      num_q[k] <= {num_in[DIV_NUM_W-2:0], ge};
    end

    if (k < DIV_NUM_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[k] <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = num_q[DIV_NUM_W-1];

endmodule

>>> hdl/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks on the barometric compensation core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "barometric_pressure_compensation_core_assert.svh"

module bpc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic cfg_ready_o,
  input logic result_valid_o
);
  import bpc_pkg::*;

  logic acc;
  assign acc = start_i && !busy_o;

  `BPC_ASSERT_IMP(a_cfg_ready, clk_i, rst_ni, 1'b1, cfg_ready_o)
  `BPC_ASSERT_DLY(a_word_out, clk_i, rst_ni, acc, PIPE_LAT, result_valid_o)
  `BPC_ASSERT_IMP(a_word_src, clk_i, rst_ni, result_valid_o, $past(acc, PIPE_LAT))

endmodule

bind barometric_pressure_compensation_core bpc_checker u_bpc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .cfg_ready_o    (cfg_ready_o),
  .result_valid_o (result_valid_o)
);

>>> tb/tb_barometric_pressure_compensation_core.sv
// ----------------------------------------------------------------------------
// tb_barometric_pressure_compensation_core
// Self-checking bench for the barometer compensation core. An in-bench
// integer model predicts temperature and pressure for each accepted sample.
// Each strobed result is compared in order. The calibration is swept through
// typical, zero, extreme and random settings, with random sender gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_barometric_pressure_compensation_core;
  import bpc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [19:0]        press;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [15:0] raw_temperature_i = '0;
  logic [7:0] press_msb_i = '0;
  logic [7:0] press_lsb_i = '0;
  logic [7:0] press_xlsb_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic result_valid_o;
  logic signed [15:0] temperature_tenths_o;
  logic [19:0] pressure_pa_o;

  // calibration as the core should hold it
  logic [47:0] cal_a123;
  logic [15:0] cal_a4, cal_a5, cal_a6;
  logic [31:0] cal_b, cal_m;
  logic [1:0]  oss_r;

  reading_t expected_q[$];
  int fail_count = 0;
  int cycle_count = 0;
  int gap_pct = 0;

  barometric_pressure_compensation_core u_top (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic reading_t compensate(logic [15:0] ut_w, logic [7:0] msb,
                                          logic [7:0] lsb, logic [7:0] xlsb);
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
    longint x1, x2, x3, dv, b5, b6, sq, b3, t, p;
    logic [31:0] b4, b7, prod;
    logic [63:0] q;
    reading_t r;
    ac1 = sx16(cal_a123[47:32]);
    ac2 = sx16(cal_a123[31:16]);
    ac3 = sx16(cal_a123[15:0]);
    ac4 = longint'({48'd0, cal_a4});
    ac5 = longint'({48'd0, cal_a5});
    ac6 = longint'({48'd0, cal_a6});
    b1 = sx16(cal_b[31:16]);
    b2 = sx16(cal_b[15:0]);
    mc = sx16(cal_m[31:16]);
    md = sx16(cal_m[15:0]);
    ut = longint'({48'd0, ut_w});
    up = longint'({40'd0, msb, lsb, xlsb} >> (8 - oss_r));

    x1 = ((ut - ac6) * ac5) >>> 15;
    dv = x1 + md;
    x2 = (dv != 0) ? (mc * 2048) / dv : 64'sd0;
    b5 = x1 + x2;
    t = (b5 + 8) >>> 4;
    if (t > TEMP_MAX) t = longint'(TEMP_MAX);
    if (t < TEMP_MIN) t = longint'(TEMP_MIN);

    b6 = b5 - B6_OFFSET;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = ((ac1 * 4 + x3) * (longint'(1) << oss_r) + 2) >>> 2;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    prod = ac4[31:0] * 32'(x3 + B4_OFFSET);
    b4 = prod >> 15;
    b7 = (32'(up) - 32'(b3)) * (32'(B7_SCALE) >> oss_r);

    if (b4 == 0) begin
      p = longint'(PRESS_MAX);
    end else begin
      if (b7 < 32'h8000_0000) q = (64'(b7) * 2) / 64'(b4);
      else q = (64'(b7) / 64'(b4)) * 2;
      p = longint'(q);
      x1 = (p >>> 8) * (p >>> 8);
      x1 = (x1 * P_C1) >>> 16;
      x2 = (P_C2 * p) >>> 16;
      p = p + ((x1 + x2 + P_C3) >>> 4);
      if (p > PRESS_MAX) p = longint'(PRESS_MAX);
      if (p < 0) p = 64'sd0;
    end
    r.temp = t[15:0];
    r.press = p[19:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
             cycle_count);
    fail_count++;
  endtask

  // track config writes and accepted samples, check results
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      cal_a123 <= '0; cal_a4 <= '0; cal_a5 <= '0; cal_a6 <= '0;
      cal_b <= '0; cal_m <= '0; oss_r <= '0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_A_FIRST_THREE: cal_a123 <= cfg_data_i[47:0];
          CFG_A_FOUR:        cal_a4 <= cfg_data_i[15:0];
          CFG_A_FIVE:        cal_a5 <= cfg_data_i[15:0];
          CFG_A_SIX:         cal_a6 <= cfg_data_i[15:0];
          CFG_B_PAIR:        cal_b <= cfg_data_i[31:0];
          CFG_M_PAIR:        cal_m <= cfg_data_i[31:0];
          CFG_OVERSAMPLING:  oss_r <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_o)
        expected_q.push_back(compensate(raw_temperature_i, press_msb_i,
                                        press_lsb_i, press_xlsb_i));
      if (result_valid_o) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", pressure_pa_o, -1);
        end else begin
          want = expected_q.pop_front();
          if (temperature_tenths_o !== want.temp)
            report_mismatch("temperature_tenths", temperature_tenths_o, want.temp);
          if (pressure_pa_o !== want.press)
            report_mismatch("pressure_pa", pressure_pa_o, want.press);
        end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout");
        $display("barometric_pressure_compensation_core regression: fail");
        $finish;
      end
    end
  end

  task automatic send_sample(logic [15:0] ut, logic [7:0] msb, logic [7:0] lsb,
                             logic [7:0] xlsb);
    logic held;
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    raw_temperature_i <= ut;
    press_msb_i <= msb;
    press_lsb_i <= lsb;
    press_xlsb_i <= xlsb;
    do begin
      @(negedge clk_i);
      held = busy_o;
      @(posedge clk_i);
    end while (held);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (expected_q.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    logic ok;
    drain();
    repeat (PIPE_LAT + 4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
    end while (!ok);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_cal(logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2,
                          mc, md, logic [1:0] oss);
    write_cfg(CFG_A_FIRST_THREE, {ac1, ac2, ac3});
    write_cfg(CFG_A_FOUR, CFG_DATA_W'(ac4));
    write_cfg(CFG_A_FIVE, CFG_DATA_W'(ac5));
    write_cfg(CFG_A_SIX, CFG_DATA_W'(ac6));
    write_cfg(CFG_B_PAIR, CFG_DATA_W'({b1, b2}));
    write_cfg(CFG_M_PAIR, CFG_DATA_W'({mc, md}));
    write_cfg(CFG_OVERSAMPLING, CFG_DATA_W'(oss));
  endtask

  task automatic load_typical(logic [1:0] oss);
    load_cal(16'd408, -16'sd72, -16'sd14383, 16'd32741, 16'd32757, 16'd23153,
             16'd6190, 16'd4, -16'sd8711, 16'd2868, oss);
  endtask

  task automatic send_corners();
    send_sample(16'd0, 8'd0, 8'd0, 8'd0);
    send_sample(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_sample(16'd27898, 8'h5D, 8'h23, 8'h00);
    send_sample(16'h8000, 8'h80, 8'h01, 8'hAA);
  endtask

  // reset calibration: zero divisors on both paths
  task automatic test_reset_calibration();
    send_corners();
  endtask

  task automatic test_typical_oversampling();
    for (int o = 0; o < 4; o++) begin
      load_typical(o[1:0]);
      send_corners();
    end
  endtask

  task automatic test_extreme_calibration();
    // all ones, then temperature saturation both ways
    load_cal('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, 2'd3);
    send_corners();
    load_cal(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd0, 16'd0, 16'h8000,
             16'h7FFF, 16'h7FFF, 16'd1, 2'd1);
    send_sample(16'd100, 8'h12, 8'h34, 8'h56);
    write_cfg(CFG_M_PAIR, CFG_DATA_W'({16'h8000, 16'd1}));
    send_sample(16'd100, 8'hFE, 8'hDC, 8'hBA);
    // ignored index leaves calibration alone
    write_cfg(CFG_IDX_UNUSED, '1);
    send_sample(16'd200, 8'h01, 8'h02, 8'h03);
  endtask

  task automatic load_random();
    if ($urandom_range(1)) begin
      load_typical(2'($urandom_range(3)));
      write_cfg(CFG_M_PAIR,
                CFG_DATA_W'({16'($urandom), 16'($urandom_range(1, 6000))}));
    end else begin
      load_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom), 2'($urandom_range(3)));
    end
  endtask

  task automatic test_random_phase(int pct, int count);
    gap_pct = pct;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) load_random();
      if (i == count / 2) drain();
      send_sample(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_calibration();
    test_typical_oversampling();
    test_extreme_calibration();
    test_random_phase(33, 400);
    test_random_phase(74, 400);
    test_random_phase(0, 400);
    drain();
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("barometric_pressure_compensation_core regression: pass");
    end else begin
      $display("barometric_pressure_compensation_core regression: fail");
    end
    $finish;
  end

endmodule

>>> barometric_pressure_compensation_core.f
+incdir+hdl
hdl/bpc_pkg.sv
hdl/bpc_udiv.sv
hdl/barometric_pressure_compensation_core.sv
hdl/bpc_checker.sv
tb/tb_barometric_pressure_compensation_core.sv
